[design/png_csp_pkg.sv]
`timescale 1ns / 1ps

package png_csp_pkg;

  // chunk type codes, big-endian ascii
  localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
  localparam logic [31:0] TYPE_IDAT = 32'h4944_4154;
  localparam logic [31:0] TYPE_IEND = 32'h4945_4e44;
  localparam logic [31:0] IHDR_LEN  = 32'd13;

  localparam logic [31:0] SIG_LAST   = 32'd7;
  localparam logic [31:0] FIELD_LAST = 32'd3;

  // per-word event codes
  typedef enum logic [2:0] {
    EV_BYTE   = 3'd0,
    EV_DATA   = 3'd1,
    EV_HEADER = 3'd2,
    EV_END    = 3'd3,
    EV_ERROR  = 3'd4
  } event_t;

  typedef enum logic [8:0] {
    PH_SIG  = 9'b000000001,
    PH_LEN  = 9'b000000010,
    PH_TYPE = 9'b000000100,
    PH_HDR  = 9'b000001000,
    PH_DATA = 9'b000010000,
    PH_SKIP = 9'b000100000,
    PH_CRC  = 9'b001000000,
    PH_DONE = 9'b010000000,
    PH_FAIL = 9'b100000000
  } phase_t;

  // one result word
  typedef struct packed {
    event_t      event_res;
    logic [7:0]  interlace_method;
    logic [7:0]  filter_method;
    logic [7:0]  compression_method;
    logic [7:0]  color_type;
    logic [7:0]  bit_depth;
    logic [31:0] image_height;
    logic [31:0] image_width;
    logic [7:0]  payload_byte;
  } result_t;

  // legal colour type / bit depth combinations
  function automatic logic pair_ok(input logic [7:0] color, input logic [7:0] depth);
    logic low;
    logic ok;
    low = (depth == 8'd1) || (depth == 8'd2) || (depth == 8'd4) || (depth == 8'd8);
    case (color)
      8'd0: ok = low || (depth == 8'd16);
      8'd3: ok = low;
      8'd2, 8'd4, 8'd6: ok = (depth == 8'd8) || (depth == 8'd16);
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

[design/png_chunk_stream_parser_core.sv]
`timescale 1ns / 1ps

// png chunk stream parser: takes a png file one byte per input word, starting at the
// signature, which is skipped unchecked. chunks are framed as length, type, payload and
// crc (crc skipped, not verified). ihdr must come first with length 13, nonzero width and
// height and a legal colour type / bit depth pair; its fields are latched and reported on
// every result word (zero until the header is accepted). idat payload bytes are streamed
// out with event 1, unknown chunks are skipped, iend must have length 0 and its last crc
// byte gives event 3, as does every later byte. any failure is sticky: every later word
// gives event 4. each input word yields exactly one result word. throughput is one word
// per clock while the output accepts (s_tready drops when the skid register is full): the
// chunk state and the 32-bit payload counter update together, and the result is
// registered. a two-entry output stage (result register plus skid register) lets input
// keep flowing for one word while the output side stalls.
module png_chunk_stream_parser_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [7:0]    s_tdata,   // [7:0] stream_byte
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [111:0]  m_tdata,   // [7:0] payload_byte, [39:8] image_width,
                                   // [71:40] image_height, [79:72] bit_depth,
                                   // [87:80] color_type, [95:88] compression_method,
                                   // [103:96] filter_method, [111:104] interlace_method
  output logic [2:0]    m_tuser    // [2:0] event_res
);

  // parser state
  png_csp_pkg::phase_t phase, phase_next;
  logic [31:0] byte_count, byte_count_next;
  logic [31:0] chunk_length, chunk_length_next;
  logic [31:0] chunk_type, chunk_type_next;
  logic        header_seen, header_seen_next;
  logic [31:0] width_store, width_store_next;
  logic [31:0] height_store, height_store_next;
  logic [7:0]  depth_store, depth_store_next;
  logic [7:0]  color_store, color_store_next;
  logic [7:0]  compression_store, compression_store_next;
  logic [7:0]  filter_store, filter_store_next;
  logic [7:0]  interlace_store, interlace_store_next;

  // output stage
  png_csp_pkg::result_t out_word, skid_word, result_next;
  logic out_valid, skid_valid;

  logic        accept;
  logic [31:0] count_inc;
  logic [7:0]  in_byte;
  png_csp_pkg::event_t ev;
  logic [7:0]  pay;

  assign in_byte   = s_tdata;
  assign s_tready  = !skid_valid;
  assign accept    = s_tvalid && s_tready;
  assign count_inc = byte_count + 32'd1;

  // one step of the chunk framer
  always_comb begin
    phase_next             = phase;
    byte_count_next        = count_inc;
    chunk_length_next      = chunk_length;
    chunk_type_next        = chunk_type;
    header_seen_next       = header_seen;
    width_store_next       = width_store;
    height_store_next      = height_store;
    depth_store_next       = depth_store;
    color_store_next       = color_store;
    compression_store_next = compression_store;
    filter_store_next      = filter_store;
    interlace_store_next   = interlace_store;
    ev  = png_csp_pkg::EV_BYTE;
    pay = 8'd0;

    case (phase)
      png_csp_pkg::PH_SIG: begin
        if (byte_count == png_csp_pkg::SIG_LAST) begin
          phase_next      = png_csp_pkg::PH_LEN;
          byte_count_next = 32'd0;
        end
      end
      png_csp_pkg::PH_LEN: begin
        chunk_length_next = {chunk_length[23:0], in_byte};
        if (byte_count == png_csp_pkg::FIELD_LAST) begin
          phase_next      = png_csp_pkg::PH_TYPE;
          byte_count_next = 32'd0;
        end
      end
      png_csp_pkg::PH_TYPE: begin
        chunk_type_next = {chunk_type[23:0], in_byte};
        if (byte_count == png_csp_pkg::FIELD_LAST) begin
          byte_count_next = 32'd0;
          if (!header_seen && chunk_type_next != png_csp_pkg::TYPE_IHDR) begin
            ev         = png_csp_pkg::EV_ERROR;
            phase_next = png_csp_pkg::PH_FAIL;
          end else if (chunk_type_next == png_csp_pkg::TYPE_IHDR) begin
            if (header_seen || chunk_length != png_csp_pkg::IHDR_LEN) begin
              ev         = png_csp_pkg::EV_ERROR;
              phase_next = png_csp_pkg::PH_FAIL;
            end else begin
              phase_next = png_csp_pkg::PH_HDR;
            end
          end else if (chunk_type_next == png_csp_pkg::TYPE_IEND) begin
            if (chunk_length != 32'd0) begin
              ev         = png_csp_pkg::EV_ERROR;
              phase_next = png_csp_pkg::PH_FAIL;
            end else begin
              phase_next = png_csp_pkg::PH_CRC;
            end
          end else if (chunk_length == 32'd0) begin
            phase_next = png_csp_pkg::PH_CRC;
          end else if (chunk_type_next == png_csp_pkg::TYPE_IDAT) begin
            phase_next = png_csp_pkg::PH_DATA;
          end else begin
            phase_next = png_csp_pkg::PH_SKIP;
          end
        end
      end
      png_csp_pkg::PH_HDR: begin
        if (byte_count < 32'd4) width_store_next = {width_store[23:0], in_byte};
        else if (byte_count < 32'd8) height_store_next = {height_store[23:0], in_byte};
        else if (byte_count == 32'd8) depth_store_next = in_byte;
        else if (byte_count == 32'd9) color_store_next = in_byte;
        else if (byte_count == 32'd10) compression_store_next = in_byte;
        else if (byte_count == 32'd11) filter_store_next = in_byte;
        else interlace_store_next = in_byte;
        if (count_inc == png_csp_pkg::IHDR_LEN) begin
          byte_count_next = 32'd0;
          if (width_store_next == 32'd0 || height_store_next == 32'd0 ||
              !png_csp_pkg::pair_ok(color_store_next, depth_store_next)) begin
            ev         = png_csp_pkg::EV_ERROR;
            phase_next = png_csp_pkg::PH_FAIL;
          end else begin
            header_seen_next = 1'b1;
            ev               = png_csp_pkg::EV_HEADER;
            phase_next       = png_csp_pkg::PH_CRC;
          end
        end
      end
      png_csp_pkg::PH_DATA, png_csp_pkg::PH_SKIP: begin
        if (phase == png_csp_pkg::PH_DATA) begin
          ev  = png_csp_pkg::EV_DATA;
          pay = in_byte;
        end
        // length is nonzero here, so the count meets it before wrapping
        if (count_inc == chunk_length) begin
          phase_next      = png_csp_pkg::PH_CRC;
          byte_count_next = 32'd0;
        end
      end
      png_csp_pkg::PH_CRC: begin
        if (byte_count == png_csp_pkg::FIELD_LAST) begin
          byte_count_next = 32'd0;
          if (chunk_type == png_csp_pkg::TYPE_IEND) begin
            ev         = png_csp_pkg::EV_END;
            phase_next = png_csp_pkg::PH_DONE;
          end else begin
            chunk_length_next = 32'd0;
            chunk_type_next   = 32'd0;
            phase_next        = png_csp_pkg::PH_LEN;
          end
        end
      end
      png_csp_pkg::PH_DONE: begin
        byte_count_next = byte_count;
        ev              = png_csp_pkg::EV_END;
      end
      default: begin
        // failure, sticky
        byte_count_next = byte_count;
        phase_next      = png_csp_pkg::PH_FAIL;
        ev              = png_csp_pkg::EV_ERROR;
      end
    endcase
  end

  // result word, header fields shown only once the header is accepted
  always_comb begin
    result_next.event_res    = ev;
    result_next.payload_byte = pay;
    if (header_seen_next) begin
      result_next.image_width        = width_store_next;
      result_next.image_height       = height_store_next;
      result_next.bit_depth          = depth_store_next;
      result_next.color_type         = color_store_next;
      result_next.compression_method = compression_store_next;
      result_next.filter_method      = filter_store_next;
      result_next.interlace_method   = interlace_store_next;
    end else begin
      result_next.image_width        = 32'd0;
      result_next.image_height       = 32'd0;
      result_next.bit_depth          = 8'd0;
      result_next.color_type         = 8'd0;
      result_next.compression_method = 8'd0;
      result_next.filter_method      = 8'd0;
      result_next.interlace_method   = 8'd0;
    end
  end

  // state update on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= png_csp_pkg::PH_SIG;
      byte_count        <= 32'd0;
      chunk_length      <= 32'd0;
      chunk_type        <= 32'd0;
      header_seen       <= 1'b0;
      width_store       <= 32'd0;
      height_store      <= 32'd0;
      depth_store       <= 8'd0;
      color_store       <= 8'd0;
      compression_store <= 8'd0;
      filter_store      <= 8'd0;
      interlace_store   <= 8'd0;
    end else if (accept) begin
      phase             <= phase_next;
      byte_count        <= byte_count_next;
      chunk_length      <= chunk_length_next;
      chunk_type        <= chunk_type_next;
      header_seen       <= header_seen_next;
      width_store       <= width_store_next;
      height_store      <= height_store_next;
      depth_store       <= depth_store_next;
      color_store       <= color_store_next;
      compression_store <= compression_store_next;
      filter_store      <= filter_store_next;
      interlace_store   <= interlace_store_next;
    end
  end

  // output register with skid stage behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || m_tready) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= accept;
        end
      end else if (accept) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_tready) begin
      if (skid_valid) out_word <= skid_word;
      else if (accept) out_word <= result_next;
    end else if (accept) begin
      skid_word <= result_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_word.event_res;
  assign m_tdata  = {out_word.interlace_method, out_word.filter_method,
                     out_word.compression_method, out_word.color_type,
                     out_word.bit_depth, out_word.image_height,
                     out_word.image_width, out_word.payload_byte};

`ifndef SYNTHESIS
  // skid stage only fills behind a held result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid word held without output word");

  // payload is zero unless the word carries image data
  a_payload_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.event_res != png_csp_pkg::EV_DATA) |-> out_word.payload_byte == 8'd0)
    else $error("payload byte set on non-data word");

  // header acceptance is never undone
  a_header_sticky: assert property (@(posedge clk) disable iff (rst)
    header_seen |=> header_seen)
    else $error("header_seen cleared");

  // failure is sticky
  a_fail_sticky: assert property (@(posedge clk) disable iff (rst)
    (phase == png_csp_pkg::PH_FAIL) |=> (phase == png_csp_pkg::PH_FAIL))
    else $error("left failure phase");

  // an accepted data word in the data phase yields a data event
  a_data_event: assert property (@(posedge clk) disable iff (rst)
    (accept && phase == png_csp_pkg::PH_DATA) |-> ev == png_csp_pkg::EV_DATA)
    else $error("data phase without data event");
`endif

endmodule
